@@ rtl/core/fms_pkg.sv @@
// Shared types and constants for the FFT magnitude spectrum block.
// Item structs for both channels, field widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fms_pkg;

  localparam int POINTS_DEF       = 8192;
  localparam int TWIDDLE_BITS_DEF = 18;
  localparam int SAMPLE_BITS      = 16;
  localparam int BIN_BITS         = 12;
  localparam int MAG_BITS         = 29;
  localparam int WORD_BITS        = 32;
  localparam int RAD_BITS         = 64;
  localparam int ROOT_BITS        = 32;
  localparam real PI_VAL          = 3.14159265358979323846;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic                          mode;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic [BIN_BITS-1:0]           bin_index;
  } req_item_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                valid_res;
  } rsp_item_t;

endpackage

`default_nettype wire

@@ rtl/core/fms_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
// Uses fms_pkg for the radicand and root widths.
`timescale 1ns / 1ps
`default_nettype none

module fms_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [fms_pkg::RAD_BITS-1:0] radicand,
  output logic                              done,
  output logic [fms_pkg::ROOT_BITS-1:0]     root
);
  import fms_pkg::*;

  localparam int CW = $clog2(ROOT_BITS);

  logic [RAD_BITS-1:0] rem;
  logic [RAD_BITS-1:0] res;
  logic [RAD_BITS-1:0] one_bit;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [RAD_BITS-1:0] trial;

  assign trial = res + one_bit;
  assign root  = res[ROOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CW'(ROOT_BITS - 1);
        rem     <= radicand;
        res     <= '0;
        one_bit <= RAD_BITS'(1) << (RAD_BITS - 2);
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + one_bit;
        end else begin
          res <= res >> 1;
        end
        one_bit <= one_bit >> 2;
        cnt     <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fft_magnitude_spectrum_top.sv @@
// Channel   | Direction | Handshake             | Payload
// req       | in        | req_valid / req_stall | req_item  (fms_pkg::req_item_t)
// rsp       | out       | rsp_valid / rsp_stall | rsp_item  (fms_pkg::rsp_item_t)
//
// A load item without last leaves the block idle. A load with last runs zero
// padding (one missing sample at a time) and then the transform: each butterfly
// runs ST_BF_RD to ST_BF_WR1 through the single write port of the working store.
// A read item stalls the input until its result enters the result register; for a
// bin below POINTS/2 after a transform it runs the 32-step bit-serial square root.
// Reset clears control only; the store is not cleared, and reads give no magnitude until the first transform.
// A result waiting on rsp_stall does not block new loads.
// Depends on fms_pkg and fms_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module fft_magnitude_spectrum_top #(
  parameter int POINTS       = fms_pkg::POINTS_DEF,
  parameter int TWIDDLE_BITS = fms_pkg::TWIDDLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire fms_pkg::req_item_t req_item,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output fms_pkg::rsp_item_t      rsp_item
);
  import fms_pkg::*;

  localparam int AW    = $clog2(POINTS);
  localparam int HW    = AW - 1;
  localparam int HALF  = POINTS / 2;
  localparam int CNTW  = AW + 1;
  localparam int STW   = $clog2(AW);
  localparam int TW    = TWIDDLE_BITS;
  localparam int F     = TW - 1;
  localparam int PW    = TW + WORD_BITS;
  localparam int SUMW  = PW + 1;
  localparam int BINW  = (AW > BIN_BITS) ? AW : BIN_BITS;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_PAD     = 12'b000000000010,
    ST_BF_RD   = 12'b000000000100,
    ST_BF_MUL  = 12'b000000001000,
    ST_BF_ADD  = 12'b000000010000,
    ST_BF_WR0  = 12'b000000100000,
    ST_BF_WR1  = 12'b000001000000,
    ST_RD_MUL  = 12'b000010000000,
    ST_RD_SUM  = 12'b000100000000,
    ST_RD_SQRT = 12'b001000000000,
    ST_RD_DONE = 12'b010000000000,
    ST_RD_NONE = 12'b100000000000
  } state_t;

  function automatic longint tw_val(input int k, input bit use_sin);
    real    ang;
    real    c;
    real    m;
    longint r;
    ang = 2.0 * PI_VAL * k / POINTS;
    c   = use_sin ? $sin(ang) : $cos(ang);
    m   = (c < 0.0) ? -c : c;
    r   = longint'($floor(m * (2.0 ** F) + 0.5));
    if (r > (longint'(1) << F) - 1) r = (longint'(1) << F) - 1;
    return (c < 0.0) ? -r : r;
  endfunction

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) r[b] = x[AW-1-b];
    return r;
  endfunction

  // twiddle ROM, read registered
  logic signed [TW-1:0] cos_tab [HALF];
  logic signed [TW-1:0] sin_tab [HALF];
  for (genvar g = 0; g < HALF; g++) begin : g_tw
    assign cos_tab[g] = TW'(tw_val(g, 1'b0));
    assign sin_tab[g] = TW'(tw_val(g, 1'b1));
  end

  logic signed [WORD_BITS-1:0] re_mem [POINTS];
  logic signed [WORD_BITS-1:0] im_mem [POINTS];

  state_t               state;
  logic [CNTW-1:0]      load_count;
  logic                 spectrum_ready;
  logic [STW-1:0]       stage;
  logic [HW-1:0]        bf_cnt;

  logic [HW-1:0]        bf_mask;
  logic [HW-1:0]        bf_low;
  logic [HW-1:0]        bf_high;
  logic [AW-1:0]        addr_i;
  logic [AW-1:0]        addr_j;
  logic [HW-1:0]        tw_idx;
  logic [AW-1:0]        raddr_a;
  logic [BINW-1:0]      bin_ext;
  logic                 bin_ok;

  logic signed [WORD_BITS-1:0] re_a_q, im_a_q, re_b_q, im_b_q;
  logic signed [TW-1:0]        cos_q, sin_q;
  logic signed [WORD_BITS-1:0] a_re, a_im;
  logic signed [PW-1:0]        p_cr, p_si, p_ci, p_sr;
  logic signed [SUMW-1:0]      sum_re, sum_im;
  logic signed [WORD_BITS-1:0] t_re, t_im;
  logic [RAD_BITS-1:0]         sq_re, sq_im;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic signed [WORD_BITS-1:0] wre, wim;

  logic                        sqrt_start;
  logic                        sqrt_done;
  logic [ROOT_BITS-1:0]        sqrt_root;
  logic [ROOT_BITS-1:0]        root_q;
  logic                        res_valid;

  logic accept;
  logic last_bf;
  logic [CNTW-1:0] count_next;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  assign bf_mask = (HW'(1) << stage) - HW'(1);
  assign bf_low  = bf_cnt & bf_mask;
  assign bf_high = bf_cnt & ~bf_mask;
  assign addr_i  = {bf_high, 1'b0} | {1'b0, bf_low};
  assign addr_j  = addr_i | (AW'(1) << stage);
  assign tw_idx  = bf_low << (STW'(HW) - stage);
  assign last_bf = (bf_cnt == HW'(HALF - 1));

  assign bin_ext = BINW'(req_item.bin_index);
  assign bin_ok  = (bin_ext < BINW'(HALF)) && spectrum_ready;
  assign raddr_a = (state == ST_IDLE) ? bin_ext[AW-1:0] : addr_i;

  assign count_next = (load_count < CNTW'(POINTS)) ? load_count + CNTW'(1) : load_count;

  // single write port: load, padding, butterfly upper then lower
  always_comb begin
    we    = 1'b0;
    waddr = addr_i;
    wre   = a_re + t_re;
    wim   = a_im + t_im;
    unique case (state)
      ST_IDLE: begin
        we    = accept && (req_item.mode == MODE_LOAD) && (load_count < CNTW'(POINTS));
        waddr = bitrev(load_count[AW-1:0]);
        wre   = WORD_BITS'(req_item.sample);
        wim   = '0;
      end
      ST_PAD: begin
        we    = 1'b1;
        waddr = bitrev(load_count[AW-1:0]);
        wre   = '0;
        wim   = '0;
      end
      ST_BF_WR0: we = 1'b1;
      ST_BF_WR1: begin
        we    = 1'b1;
        waddr = addr_j;
        wre   = a_re - t_re;
        wim   = a_im - t_im;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      re_mem[waddr] <= wre;
      im_mem[waddr] <= wim;
    end
    re_a_q <= re_mem[raddr_a];
    im_a_q <= im_mem[raddr_a];
    re_b_q <= re_mem[addr_j];
    im_b_q <= im_mem[addr_j];
    cos_q  <= cos_tab[tw_idx];
    sin_q  <= sin_tab[tw_idx];
  end

  // butterfly and magnitude datapath
  assign sum_re = SUMW'(p_cr) + SUMW'(p_si) + (SUMW'(1) <<< (F - 1));
  assign sum_im = SUMW'(p_ci) - SUMW'(p_sr) + (SUMW'(1) <<< (F - 1));

  always_ff @(posedge clk) begin
    if (state == ST_BF_MUL) begin
      a_re <= re_a_q;
      a_im <= im_a_q;
      p_cr <= PW'(cos_q) * PW'(re_b_q);
      p_si <= PW'(sin_q) * PW'(im_b_q);
      p_ci <= PW'(cos_q) * PW'(im_b_q);
      p_sr <= PW'(sin_q) * PW'(re_b_q);
    end
    if (state == ST_BF_ADD) begin
      t_re <= WORD_BITS'(sum_re >>> F);
      t_im <= WORD_BITS'(sum_im >>> F);
    end
    if (state == ST_RD_MUL) begin
      sq_re <= RAD_BITS'(64'(re_a_q) * 64'(re_a_q));
      sq_im <= RAD_BITS'(64'(im_a_q) * 64'(im_a_q));
    end
    if (sqrt_done) root_q <= sqrt_root;
  end

  assign sqrt_start = (state == ST_RD_SUM);

  fms_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq_re + sq_im),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      load_count     <= '0;
      spectrum_ready <= 1'b0;
      stage          <= '0;
      bf_cnt         <= '0;
      res_valid      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_item.mode == MODE_LOAD) begin
              spectrum_ready <= 1'b0;
              load_count     <= count_next;
              if (req_item.last) begin
                stage  <= '0;
                bf_cnt <= '0;
                state  <= (count_next == CNTW'(POINTS)) ? ST_BF_RD : ST_PAD;
              end
            end else begin
              res_valid <= bin_ok;
              state     <= bin_ok ? ST_RD_MUL : ST_RD_NONE;
            end
          end
        end
        ST_PAD: begin
          load_count <= load_count + CNTW'(1);
          if (load_count == CNTW'(POINTS - 1)) state <= ST_BF_RD;
        end
        ST_BF_RD:  state <= ST_BF_MUL;
        ST_BF_MUL: state <= ST_BF_ADD;
        ST_BF_ADD: state <= ST_BF_WR0;
        ST_BF_WR0: state <= ST_BF_WR1;
        ST_BF_WR1: begin
          bf_cnt <= bf_cnt + HW'(1);
          state  <= ST_BF_RD;
          if (last_bf) begin
            bf_cnt <= '0;
            if (stage == STW'(AW - 1)) begin
              state          <= ST_IDLE;
              load_count     <= '0;
              spectrum_ready <= 1'b1;
            end else begin
              stage <= stage + STW'(1);
            end
          end
        end
        ST_RD_MUL:  state <= ST_RD_SUM;
        ST_RD_SUM:  state <= ST_RD_SQRT;
        ST_RD_SQRT: if (sqrt_done) state <= ST_RD_DONE;
        ST_RD_DONE, ST_RD_NONE: begin
          if (!rsp_valid || !rsp_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if ((state == ST_RD_DONE || state == ST_RD_NONE) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RD_DONE || state == ST_RD_NONE) && (!rsp_valid || !rsp_stall)) begin
      rsp_item.valid_res <= res_valid && (state == ST_RD_DONE);
      if (state == ST_RD_NONE) begin
        rsp_item.magnitude <= '0;
      end else if (root_q > ROOT_BITS'({MAG_BITS{1'b1}})) begin
        rsp_item.magnitude <= '1;
      end else begin
        rsp_item.magnitude <= root_q[MAG_BITS-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fms_checker.sv @@
// Port-level checks for the FFT magnitude spectrum block, bound to the top level.
// Uses fms_pkg item types.
`timescale 1ns / 1ps
`default_nettype none

module fms_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_stall,
  input wire fms_pkg::req_item_t req_item,
  input wire logic               rsp_valid,
  input wire logic               rsp_stall,
  input wire fms_pkg::rsp_item_t rsp_item
);
  import fms_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp_item))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_item.valid_res |-> rsp_item.magnitude == '0)
    else $error("magnitude without a finished transform");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result present after reset");

  a_load_no_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req_item.mode == MODE_LOAD && !rsp_valid |=> !rsp_valid)
    else $error("load item produced a result");

endmodule

bind fft_magnitude_spectrum_top fms_checker u_fms_checker (.*);

`default_nettype wire

@@ test/fft_magnitude_spectrum_top_tb.sv @@
// Testbench for fft_magnitude_spectrum_top: short random frames and random bin
// reads, checked against an in-bench fixed-point FFT predictor.
// Depends on fms_pkg and the block's RTL.
`timescale 1ns / 1ps

module fft_magnitude_spectrum_top_tb;
  import fms_pkg::*;

  localparam int NPTS      = 8192;
  localparam int LOG_NPTS  = 13;
  localparam int FRAC      = 17;
  localparam int IDLE_LIMIT = 2000000;
  localparam bit [63:0] PI4_Q62 = 64'h3243F6A8885A308D;
  localparam bit [63:0] ONE_Q62 = 64'h4000000000000000;
  localparam bit [63:0] MAG_SAT = 64'h1FFFFFFF;

  typedef struct {
    req_item_t item;
    bit        drain;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req_item = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp_item;

  fft_magnitude_spectrum_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  int        twid_cos[NPTS/2];
  int        twid_sin[NPTS/2];
  int        spec_re[NPTS];
  int        spec_im[NPTS];
  int        frame_fill;
  bit        spectrum_ready;

  pending_t  pending_reqs[$];
  rsp_item_t expected_mags[$];
  int        errors;
  int        accepted_reqs;
  int        idle_cycles;

  function automatic bit [63:0] mul_q62(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic int twid_round(bit [63:0] v);
    bit [63:0] r;
    r = (v + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
    if (r > (64'd1 << FRAC) - 1) r = (64'd1 << FRAC) - 1;
    return int'(r);
  endfunction

  // Twiddles from a Q62 Taylor series on the first octant, folded by symmetry
  function automatic void build_twiddles();
    bit [63:0] mask, t, x2, ts, tc, as_, ac;
    int        sh, q, e, r, j, c, s;
    sh = LOG_NPTS - 3;
    q = NPTS / 4;
    e = NPTS / 8;
    mask = (64'd1 << sh) - 1;
    for (int k = 0; k < NPTS / 2; k++) begin
      r = (k >= q) ? k - q : k;
      j = (r <= e) ? r : q - r;
      t = (PI4_Q62 >> sh) * 64'(j) + (((PI4_Q62 & mask) * 64'(j)) >> sh);
      x2 = mul_q62(t, t);
      ts = t; tc = ONE_Q62; as_ = t; ac = ONE_Q62;
      for (int n = 1; n < 24; n++) begin
        ts = mul_q62(ts, x2) / 64'((2 * n) * (2 * n + 1));
        tc = mul_q62(tc, x2) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          as_ = as_ - ts; ac = ac - tc;
        end else begin
          as_ = as_ + ts; ac = ac + tc;
        end
      end
      if (r <= e) begin
        c = twid_round(ac); s = twid_round(as_);
      end else begin
        c = twid_round(as_); s = twid_round(ac);
      end
      if (k >= q) begin
        twid_cos[k] = -s; twid_sin[k] = c;
      end else begin
        twid_cos[k] = c; twid_sin[k] = s;
      end
    end
  endfunction

  function automatic void run_fft();
    int     rev, x, half, step, jj, tmp;
    longint wr, wi, xr, xi, tr, ti, ar, ai;
    for (int i = 0; i < NPTS; i++) begin
      rev = 0; x = i;
      for (int b = 0; b < LOG_NPTS; b++) begin
        rev = (rev << 1) | (x & 1);
        x = x >> 1;
      end
      if (i < rev) begin
        tmp = spec_re[i]; spec_re[i] = spec_re[rev]; spec_re[rev] = tmp;
        tmp = spec_im[i]; spec_im[i] = spec_im[rev]; spec_im[rev] = tmp;
      end
    end
    for (int len = 2; len <= NPTS; len = len * 2) begin
      half = len / 2;
      step = NPTS / len;
      for (int m = 0; m < half; m++) begin
        wr = twid_cos[m * step];
        wi = -longint'(twid_sin[m * step]);
        for (int i = m; i < NPTS; i += len) begin
          jj = i + half;
          xr = spec_re[jj]; xi = spec_im[jj];
          tr = (wr * xr - wi * xi + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
          ti = (wr * xi + wi * xr + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
          ar = spec_re[i]; ai = spec_im[i];
          spec_re[jj] = int'(ar - tr);
          spec_im[jj] = int'(ai - ti);
          spec_re[i]  = int'(ar + tr);
          spec_im[i]  = int'(ai + ti);
        end
      end
    end
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] n);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Advance the predictor by one accepted item; queue the result of a read
  function automatic void apply_request(req_item_t it);
    rsp_item_t exp_r;
    longint    re, im;
    bit [63:0] mag;
    if (it.mode == MODE_LOAD) begin
      spectrum_ready = 1'b0;
      if (frame_fill < NPTS) begin
        spec_re[frame_fill] = int'(it.sample);
        spec_im[frame_fill] = 0;
        frame_fill++;
      end
      if (it.last) begin
        for (int i = frame_fill; i < NPTS; i++) begin
          spec_re[i] = 0; spec_im[i] = 0;
        end
        run_fft();
        frame_fill = 0;
        spectrum_ready = 1'b1;
      end
    end else begin
      exp_r = '0;
      if (spectrum_ready && int'(it.bin_index) < NPTS / 2) begin
        re = spec_re[it.bin_index];
        im = spec_im[it.bin_index];
        mag = int_sqrt(64'(re * re) + 64'(im * im));
        if (mag > MAG_SAT) mag = MAG_SAT;
        exp_r.magnitude = mag[MAG_BITS-1:0];
        exp_r.valid_res = 1'b1;
      end
      expected_mags.push_back(exp_r);
    end
  endfunction

  // Mostly short gaps, a few long ones; every fourth stretch runs with no gaps
  function automatic int pick_gap();
    int r;
    if ((accepted_reqs / 150) % 4 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_req(logic mode, logic signed [15:0] smp, logic lst,
                          logic [11:0] bin, bit drain = 1'b0);
    pending_t p;
    p.item.mode = mode;
    p.item.sample = smp;
    p.item.last = lst;
    p.item.bin_index = bin;
    p.drain = drain;
    pending_reqs.push_back(p);
  endtask

  task automatic push_random_frame(int n);
    logic signed [15:0] s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       s = 16'sh7FFF;
        1:       s = -16'sh8000;
        default: s = 16'($urandom);
      endcase
      push_req(MODE_LOAD, s, i == n - 1, 12'($urandom));
      // a stray read inside the frame sees no spectrum
      if ($urandom_range(0, 15) == 0) push_req(MODE_READ, 16'($urandom), 0, 12'($urandom));
    end
  endtask

  task automatic push_random_reads(int n);
    for (int i = 0; i < n; i++) begin
      push_req(MODE_READ, 16'($urandom), $urandom_range(0, 1), 12'($urandom));
    end
  endtask

  // Driver
  int drive_gap;
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      drive_gap <= 0;
    end else if (!req_valid || !req_stall) begin
      if (drive_gap > 0) begin
        drive_gap <= drive_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain &&
                     (req_valid || expected_mags.size() != 0))) begin
        req_item  <= pending_reqs[0].item;
        req_valid <= 1'b1;
        void'(pending_reqs.pop_front());
        drive_gap <= pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver stall
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rsp_stall  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // Monitor, checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        apply_request(req_item);
        accepted_reqs++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_mags.size() == 0) begin
          $error("result with none expected: magnitude %0d valid_res %0d",
                 rsp_item.magnitude, rsp_item.valid_res);
          errors++;
        end else begin
          if (rsp_item.magnitude !== expected_mags[0].magnitude) begin
            $error("magnitude: expected %0d, got %0d",
                   expected_mags[0].magnitude, rsp_item.magnitude);
            errors++;
          end
          if (rsp_item.valid_res !== expected_mags[0].valid_res) begin
            $error("valid_res: expected %0d, got %0d",
                   expected_mags[0].valid_res, rsp_item.valid_res);
            errors++;
          end
          void'(expected_mags.pop_front());
        end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    errors = 0;
    accepted_reqs = 0;
    idle_cycles = 0;
    frame_fill = 0;
    spectrum_ready = 1'b0;
    build_twiddles();

    // Directed: reads with no spectrum, an extreme short frame, edge bins
    push_req(MODE_READ, 0, 0, 12'd0);
    push_req(MODE_READ, 0, 0, 12'd4095);
    push_req(MODE_LOAD, 16'sh7FFF, 0, 0);
    push_req(MODE_LOAD, -16'sh8000, 0, 0);
    push_req(MODE_LOAD, 16'sd0, 0, 0);
    push_req(MODE_LOAD, 16'sd1, 0, 0);
    push_req(MODE_LOAD, -16'sd1, 1, 12'hFFF);
    push_req(MODE_READ, 0, 0, 12'd0);
    push_req(MODE_READ, 0, 0, 12'd1);
    push_req(MODE_READ, 0, 0, 12'd2);
    push_req(MODE_READ, 16'shFFFF, 1, 12'd2048);
    push_req(MODE_READ, 0, 0, 12'd4095);
    // a new load clears the spectrum
    push_req(MODE_LOAD, 16'sh7FFF, 0, 0, 1'b1);
    push_req(MODE_READ, 0, 0, 12'd0);
    push_req(MODE_READ, 0, 0, 12'd4095);

    // Random frame continuing the one just started, then reads of its spectrum
    push_random_frame(200);
    push_random_reads(300);

    // Short random frame after the pipeline has emptied
    pending_reqs[pending_reqs.size() - 1].drain = 1'b1;
    push_random_frame($urandom_range(1, 300));
    push_random_reads(450);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || expected_mags.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
